/* design/mtve_pkg.sv */
// Package: types, tables and constants for the marching tetrahedra voxel edge block.
`timescale 1ns / 1ps
`default_nettype none
package mtve_pkg;

    localparam int TETRA_COUNT = 6;

    // Tetrahedron k uses ring entries k and k+1 as its third and fourth corners.
    localparam logic [2:0] RING [7] = '{3'd6, 3'd4, 3'd5, 3'd1, 3'd3, 3'd2, 3'd6};

    localparam logic [1:0] TRI_TOTAL [16] = '{
        2'd0, 2'd1, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2, 2'd1,
        2'd1, 2'd2, 2'd2, 2'd1, 2'd2, 2'd1, 2'd1, 2'd0
    };

    // Entry is {first vertex position, second vertex position}.
    localparam logic [3:0] EDGE_TABLE [16][2][3] = '{
        '{'{4'h0, 4'h0, 4'h0}, '{4'h0, 4'h0, 4'h0}},
        '{'{4'h2, 4'h1, 4'h3}, '{4'h0, 4'h0, 4'h0}},
        '{'{4'h4, 4'h6, 4'h7}, '{4'h0, 4'h0, 4'h0}},
        '{'{4'h6, 4'h7, 4'h3}, '{4'h3, 4'h2, 4'h6}},
        '{'{4'h8, 4'hB, 4'h9}, '{4'h0, 4'h0, 4'h0}},
        '{'{4'h3, 4'hB, 4'h9}, '{4'h9, 4'h1, 4'h3}},
        '{'{4'h4, 4'h8, 4'hB}, '{4'hB, 4'h7, 4'h4}},
        '{'{4'hB, 4'h7, 4'h3}, '{4'h0, 4'h0, 4'h0}},
        '{'{4'hC, 4'hD, 4'hE}, '{4'h0, 4'h0, 4'h0}},
        '{'{4'hE, 4'h2, 4'h1}, '{4'h1, 4'hD, 4'hE}},
        '{'{4'h6, 4'hE, 4'hC}, '{4'hC, 4'h4, 4'h6}},
        '{'{4'h6, 4'hE, 4'h2}, '{4'h0, 4'h0, 4'h0}},
        '{'{4'hC, 4'hD, 4'h9}, '{4'h9, 4'h8, 4'hC}},
        '{'{4'hD, 4'h9, 4'h1}, '{4'h0, 4'h0, 4'h0}},
        '{'{4'hC, 4'h4, 4'h8}, '{4'h0, 4'h0, 4'h0}},
        '{'{4'h0, 4'h0, 4'h0}, '{4'h0, 4'h0, 4'h0}}
    };

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic load;
        logic skip;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic cur_empty;
        logic rest_empty;
        logic edge_last;
        logic slot_free;
    } status_t;

    function automatic logic [3:0] tetra_code(input logic [7:0] signs, input logic [2:0] k);
        logic [2:0] k1;
        k1 = k + 3'd1;
        return {signs[RING[k1]], signs[RING[k]], signs[7], signs[0]};
    endfunction

endpackage
`default_nettype wire

/* design/mtve_ctrl.sv */
// Controller: voxel acceptance and edge walk sequencing.
`timescale 1ns / 1ps
`default_nettype none
module mtve_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  mtve_pkg::status_t     status,
    output mtve_pkg::cmd_t        cmd
);
    import mtve_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.cur_empty)
                begin
                    cmd.skip = 1'b1;
                    if (status.rest_empty)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (status.slot_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.edge_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* design/mtve_datapath.sv */
// Datapath: held voxel, walk counters, table lookup and output register.
`timescale 1ns / 1ps
`default_nettype none
module mtve_datapath (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  mtve_pkg::cmd_t    cmd,
    output mtve_pkg::status_t status,
    input  wire logic [7:0]   corner_negative,
    input  wire logic [31:0]  x_low,
    input  wire logic [31:0]  x_high,
    input  wire logic [31:0]  y_low,
    input  wire logic [31:0]  y_high,
    input  wire logic [31:0]  z_low,
    input  wire logic [31:0]  z_high,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [2:0]        inside_corner,
    output logic [2:0]        outside_corner,
    output logic [31:0]       ax,
    output logic [31:0]       ay,
    output logic [31:0]       az,
    output logic [31:0]       bx,
    output logic [31:0]       by,
    output logic [31:0]       bz,
    output logic              triangle_end,
    output logic              voxel_last
);
    import mtve_pkg::*;

    logic [7:0]  signs_reg;
    logic [31:0] coord_reg [6];
    logic [2:0]  tetra_reg;
    logic        tri_reg;
    logic [1:0]  vert_reg;

    logic        out_valid_reg;
    logic [2:0]  inside_reg;
    logic [2:0]  outside_reg;
    logic [31:0] ax_reg, ay_reg, az_reg, bx_reg, by_reg, bz_reg;
    logic        tri_end_reg;
    logic        last_reg;

    logic [TETRA_COUNT-1:0] has_tris;
    logic [3:0]  code;
    logic [1:0]  total;
    logic [3:0]  entry;
    logic [2:0]  corner [4];
    logic [2:0]  c0, c1;
    logic        tri_last;
    logic        rest_empty;

    always_comb
    begin
        for (int k = 0; k < TETRA_COUNT; k++)
        begin
            has_tris[k] = TRI_TOTAL[tetra_code(signs_reg, 3'(k))] != 2'd0;
        end
        rest_empty = 1'b1;
        for (int k = 0; k < TETRA_COUNT; k++)
        begin
            if (3'(k) > tetra_reg && has_tris[k])
            begin
                rest_empty = 1'b0;
            end
        end
        code      = tetra_code(signs_reg, tetra_reg);
        total     = TRI_TOTAL[code];
        entry     = EDGE_TABLE[code][tri_reg][vert_reg];
        corner[0] = 3'd0;
        corner[1] = 3'd7;
        corner[2] = RING[tetra_reg];
        corner[3] = RING[3'(tetra_reg + 3'd1)];
        c0        = corner[entry[3:2]];
        c1        = corner[entry[1:0]];
        tri_last  = tri_reg || (total == 2'd1);
    end

    assign status.cur_empty  = (total == 2'd0);
    assign status.rest_empty = rest_empty;
    assign status.edge_last  = (vert_reg == 2'd2) && tri_last && rest_empty;
    assign status.slot_free  = !out_valid_reg || out_ready;

    // Walk position, back to zero when the voxel is done
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tetra_reg <= '0;
            tri_reg   <= 1'b0;
            vert_reg  <= '0;
        end
        else if (cmd.load)
        begin
            tetra_reg <= '0;
            tri_reg   <= 1'b0;
            vert_reg  <= '0;
        end
        else if (cmd.skip)
        begin
            if (rest_empty)
            begin
                tetra_reg <= '0;
            end
            else
            begin
                tetra_reg <= tetra_reg + 3'd1;
            end
        end
        else if (cmd.emit)
        begin
            if (vert_reg == 2'd2)
            begin
                vert_reg <= '0;
                if (tri_last)
                begin
                    tri_reg <= 1'b0;
                    if (rest_empty)
                    begin
                        tetra_reg <= '0;
                    end
                    else
                    begin
                        tetra_reg <= tetra_reg + 3'd1;
                    end
                end
                else
                begin
                    tri_reg <= 1'b1;
                end
            end
            else
            begin
                vert_reg <= vert_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            signs_reg <= '0;
        end
        else if (cmd.load)
        begin
            signs_reg <= corner_negative;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            coord_reg[0] <= x_low;
            coord_reg[1] <= x_high;
            coord_reg[2] <= y_low;
            coord_reg[3] <= y_high;
            coord_reg[4] <= z_low;
            coord_reg[5] <= z_high;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            inside_reg  <= c0;
            outside_reg <= c1;
            ax_reg      <= c0[2] ? coord_reg[1] : coord_reg[0];
            ay_reg      <= c0[1] ? coord_reg[3] : coord_reg[2];
            az_reg      <= c0[0] ? coord_reg[5] : coord_reg[4];
            bx_reg      <= c1[2] ? coord_reg[1] : coord_reg[0];
            by_reg      <= c1[1] ? coord_reg[3] : coord_reg[2];
            bz_reg      <= c1[0] ? coord_reg[5] : coord_reg[4];
            tri_end_reg <= (vert_reg == 2'd2);
            last_reg    <= status.edge_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign inside_corner  = inside_reg;
    assign outside_corner = outside_reg;
    assign ax             = ax_reg;
    assign ay             = ay_reg;
    assign az             = az_reg;
    assign bx             = bx_reg;
    assign by             = by_reg;
    assign bz             = bz_reg;
    assign triangle_end   = tri_end_reg;
    assign voxel_last     = last_reg;

endmodule
`default_nettype wire

/* design/marching_tetrahedra_voxel_edges.sv */
// Top level: marching tetrahedra crossing-edge generator for one voxel per transfer.
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------------
//  in      | in_valid/in_ready  | corner_negative, x/y/z low and high bounds
//  out     | out_valid/out_ready| corner pair, endpoint coords, triangle_end, voxel_last
//
// One voxel at a time: after the accept, each result edge is emitted in turn and
// each uniform tetrahedron met on the walk is skipped.
// in_ready rises the cycle after the last edge is registered or an empty voxel is skipped; the sequencer walks
// tetrahedra, triangles and vertices with a single table lookup.
// Output stalls hold emits, not skips; reset clears the sequencer and the output valid.
`timescale 1ns / 1ps
`default_nettype none
module marching_tetrahedra_voxel_edges (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  corner_negative,
    input  wire logic [31:0] x_low,
    input  wire logic [31:0] x_high,
    input  wire logic [31:0] y_low,
    input  wire logic [31:0] y_high,
    input  wire logic [31:0] z_low,
    input  wire logic [31:0] z_high,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       inside_corner,
    output logic [2:0]       outside_corner,
    output logic [31:0]      ax,
    output logic [31:0]      ay,
    output logic [31:0]      az,
    output logic [31:0]      bx,
    output logic [31:0]      by,
    output logic [31:0]      bz,
    output logic             triangle_end,
    output logic             voxel_last
);
    import mtve_pkg::*;

    cmd_t    cmd;
    status_t status;

    mtve_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    mtve_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .corner_negative (corner_negative),
        .x_low           (x_low),
        .x_high          (x_high),
        .y_low           (y_low),
        .y_high          (y_high),
        .z_low           (z_low),
        .z_high          (z_high),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .inside_corner   (inside_corner),
        .outside_corner  (outside_corner),
        .ax              (ax),
        .ay              (ay),
        .az              (az),
        .bx              (bx),
        .by              (by),
        .bz              (bz),
        .triangle_end    (triangle_end),
        .voxel_last      (voxel_last)
    );

endmodule
`default_nettype wire
